### hdl/vla_pkg.sv
`default_nettype none

package vla_pkg;

    // Number of cells around one face vertex, one lane per cell.
    localparam int unsigned NUM_CELLS = 4;

    // Register stages from input to output: five in each lane, one in the merge.
    localparam int unsigned NUM_STAGES = 6;

    // Q1.16 one and the smoothstep constant 3.0 in Q2.16.
    localparam logic [17:0] ONE_Q16   = 18'd65536;
    localparam logic [17:0] THREE_Q16 = 18'd196608;

    // Shift of the fixed reciprocal used to divide by the light maximum.
    localparam int unsigned RECIP_SHIFT = 24;

    // Reciprocal of three for the averaging divide, exact for sums below 2^19.
    localparam int unsigned THIRD_SHIFT = 21;
    localparam logic [19:0] THIRD_RECIP = 20'd699051;

    // Daylight register reset value: full daylight.
    localparam logic [8:0] DAYLIGHT_RESET = 9'd256;

    typedef logic [3:0]  light_t;
    typedef logic [8:0]  scale_t;
    typedef logic [16:0] level_t;

    // Load enables of the five lane stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } lane_en_t;

endpackage

`default_nettype wire

### hdl/vla_lane.sv
`default_nettype none

module vla_lane #(
    parameter int unsigned LIGHT_MAX = 15
) (
    input  wire              clk,
    input  vla_pkg::lane_en_t en,
    input  vla_pkg::scale_t  daylight_scale,
    input  vla_pkg::light_t  block_light,
    input  vla_pkg::light_t  sky_light,
    output vla_pkg::level_t  level
);
    import vla_pkg::*;

    localparam logic [15:0] DENOM = 16'(LIGHT_MAX * 256);
    localparam logic [7:0]  LMAX  = 8'(LIGHT_MAX);
    localparam logic [24:0] RECIP = 25'((64'd1 << RECIP_SHIFT) / LIGHT_MAX);

    logic [12:0] n_reg,   n_next;
    logic [20:0] x_reg,   x_next;
    logic [16:0] q0_reg,  q0_next;
    logic [16:0] v_reg,   v_next;
    logic [16:0] v4_reg;
    logic [32:0] sq_reg,  sq_next;
    level_t      lvl_reg, lvl_next;

    logic [12:0] nb;
    logic [12:0] ns;
    logic [12:0] nmax;
    logic [45:0] recip_prod;
    logic [24:0] q_times_l;
    logic [24:0] rem;
    logic [17:0] w;
    logic [50:0] shape_prod;

    // Stage 1: pick the brighter source and clamp to full light.
    always_comb
    begin
        nb     = {1'b0, block_light, 8'b0};
        ns     = 13'(sky_light * daylight_scale);
        nmax   = (nb > ns) ? nb : ns;
        n_next = ({3'b0, nmax} > DENOM) ? DENOM[12:0] : nmax;
    end

    // Stage 2: quotient estimate of n*256/LIGHT_MAX, low by at most one.
    always_comb
    begin
        x_next     = {n_reg, 8'b0};
        recip_prod = 46'(x_next) * 46'(RECIP);
        q0_next    = recip_prod[40:24];
    end

    // Stage 3: one correction step on the remainder.
    always_comb
    begin
        q_times_l = 25'(q0_reg) * 25'(LMAX);
        rem       = {4'b0, x_reg} - q_times_l;
        v_next    = (rem >= {17'b0, LMAX}) ? q0_reg + 17'd1 : q0_reg;
    end

    // Stage 4: square.
    assign sq_next = 33'(v_reg) * 33'(v_reg);

    // Stage 5: smoothstep v*v*(3-2v).
    always_comb
    begin
        w          = THREE_Q16 - {v4_reg, 1'b0};
        shape_prod = 51'(sq_reg) * 51'(w);
        lvl_next   = shape_prod[48:32];
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            n_reg <= n_next;
        end
        if (en.s2)
        begin
            x_reg  <= x_next;
            q0_reg <= q0_next;
        end
        if (en.s3)
        begin
            v_reg <= v_next;
        end
        if (en.s4)
        begin
            sq_reg <= sq_next;
            v4_reg <= v_reg;
        end
        if (en.s5)
        begin
            lvl_reg <= lvl_next;
        end
    end

    assign level = lvl_reg;

endmodule

`default_nettype wire

### hdl/vla_merge.sv
`default_nettype none

module vla_merge (
    input  wire                   clk,
    input  wire                   en,
    input  vla_pkg::level_t [3:0] level,
    input  wire [3:0]             open_mask,
    input  wire [3:0]             inside_mask,
    output vla_pkg::level_t       vertex_light,
    output logic [2:0]            open_count
);
    import vla_pkg::*;

    logic [18:0] sum;
    logic [2:0]  count;
    logic [39:0] third_prod;
    level_t      avg;
    level_t      avg_reg;
    logic [2:0]  count_reg;

    // Cells out of range count but contribute a zero level.
    always_comb
    begin
        sum   = '0;
        count = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            if (open_mask[i])
            begin
                count = count + 3'd1;
                if (inside_mask[i])
                begin
                    sum = sum + 19'(level[i]);
                end
            end
        end
    end

    assign third_prod = 40'(sum) * 40'(THIRD_RECIP);

    always_comb
    begin
        unique case (count)
            3'd1:    avg = sum[16:0];
            3'd2:    avg = sum[17:1];
            3'd3:    avg = third_prod[THIRD_SHIFT +: 17];
            3'd4:    avg = sum[18:2];
            default: avg = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            avg_reg   <= avg;
            count_reg <= count;
        end
    end

    assign vertex_light = avg_reg;
    assign open_count   = count_reg;

endmodule

`default_nettype wire

### hdl/vertex_light_averager_unit.sv
// Smoothed light of one face vertex for a voxel mesher.
//
// Input stream (s_axis_*): one item per vertex carrying the block light and
// sky light of its four surrounding cells together with the open and inside
// masks. Output stream (m_axis_*): one item per input item, the averaged
// smoothstep light in Q1.16 and the number of cells that counted.
// Configuration (cfg_*): a write sets the 9-bit daylight scale, Q1.8, that
// multiplies sky light. It is always ready and should be written while no
// item is in flight.
//
// Four identical lanes compute the per-cell level in five register stages
// (clamp, reciprocal estimate, correction, square, smoothstep), and a merge
// stage averages the lanes into the output register. Throughput is one item
// per cycle while the receiver does not stall.
//
// Reset clears every stage valid bit and loads the daylight scale with full
// daylight (256). When the receiver stalls, each stage holds its item until
// the next stage frees up, so empty stages keep filling and the input only
// stalls once the whole pipeline is full.
`default_nettype none

module vertex_light_averager_unit #(
    parameter int unsigned LIGHT_MAX = 15
) (
    input  wire         clk,
    input  wire         rst_n,

    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // From bit 0: block_light_a..d (4 each), sky_light_a..d (4 each),
    // open_mask (4), inside_mask (4).
    input  wire  [39:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // From bit 0: vertex_light (17), open_count (3), zero fill (4).
    output logic [23:0] m_axis_tdata,

    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [8:0]  cfg_data
);
    import vla_pkg::*;

    localparam int unsigned MASK_STAGES = NUM_STAGES - 1;

    scale_t          daylight_scale_reg;
    logic [NUM_STAGES-1:0] vld_reg, vld_next;
    logic [NUM_STAGES-1:0] rdy;

    // Masks travel alongside the lane stages until the merge.
    logic [7:0]      mask_reg [MASK_STAGES];

    lane_en_t        lane_en;
    level_t [3:0]    level;
    level_t          vertex_light;
    logic [2:0]      open_count;

    // The configuration write is taken in every cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            daylight_scale_reg <= DAYLIGHT_RESET;
        end
        else if (cfg_valid)
        begin
            daylight_scale_reg <= cfg_data;
        end
    end

    // A stage may load when it is empty or when its item moves on.
    always_comb
    begin
        rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (rdy[0])
        begin
            vld_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (rdy[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            mask_reg[0] <= s_axis_tdata[39:32];
        end
        for (int k = 1; k < MASK_STAGES; k++)
        begin
            if (rdy[k])
            begin
                mask_reg[k] <= mask_reg[k-1];
            end
        end
    end

    assign lane_en = '{s1: rdy[0], s2: rdy[1], s3: rdy[2], s4: rdy[3], s5: rdy[4]};

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_lane
        vla_lane #(
            .LIGHT_MAX (LIGHT_MAX)
        ) u_lane (
            .clk            (clk),
            .en             (lane_en),
            .daylight_scale (daylight_scale_reg),
            .block_light    (s_axis_tdata[4*i +: 4]),
            .sky_light      (s_axis_tdata[16 + 4*i +: 4]),
            .level          (level[i])
        );
    end

    vla_merge u_merge (
        .clk          (clk),
        .en           (rdy[NUM_STAGES-1]),
        .level        (level),
        .open_mask    (mask_reg[MASK_STAGES-1][3:0]),
        .inside_mask  (mask_reg[MASK_STAGES-1][7:4]),
        .vertex_light (vertex_light),
        .open_count   (open_count)
    );

    assign s_axis_tready = rdy[0];
    assign m_axis_tvalid = vld_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {4'b0, open_count, vertex_light};

    // The average never exceeds full light.
    a_light_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:0] <= ONE_Q16[16:0] + 17'd0 ||
                           m_axis_tdata[16:0] == 17'h10000))
        else $error("vertex light above 1.0");

    // At most four cells can count.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[19:17] <= 3'd4)
        else $error("open count above four");

    // With no open cell the light must be zero.
    a_dark_vertex: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[19:17] == 3'd0) |-> m_axis_tdata[16:0] == 17'd0)
        else $error("light without open cells");

    // An accepted item occupies the first stage in the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted item lost at first stage");

    // An empty first stage never blocks the input.
    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> s_axis_tready)
        else $error("input stalled with empty first stage");

endmodule

`default_nettype wire
